// ===== sv/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types, constants and chord lookup functions for the chord symbol
// to note event block.
// ----------------------------------------------------------------------------
package cse_pkg;

	localparam int MAX_CHARS = 511;
	localparam int CHARS_W = $clog2(MAX_CHARS + 1);
	localparam int TOKEN_DEPTH = 6;
	localparam int LEN_W = 3;
	localparam logic [LEN_W-1:0] TOKEN_OVERFLOW = 3'd7;
	localparam logic [7:0] DASH = 8'd45;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OCTAVE     = 3'd0,
		REG_START      = 3'd1,
		REG_DURATION   = 3'd2,
		REG_INSTRUMENT = 3'd3,
		REG_AMPLITUDE  = 3'd4
	} cfg_reg_t;

	// controller -> datapath
	typedef struct packed {
		logic take;     // input word accepted
		logic parse;    // decode the held token, advance time
		logic advance;  // output word accepted, step to next tone
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic tok_done;   // accepted word completes a non-empty token
		logic last_tone;  // output word on show is the last of its chord
	} sts_t;

	typedef struct packed {
		logic       found;
		logic       two;   // root name has an accidental
		logic [3:0] pc;
	} root_t;

	typedef struct packed {
		logic       found;
		logic       four;  // four tones, else three
		logic [3:0] iv1;
		logic [3:0] iv2;
		logic [3:0] iv3;
	} qual_t;

	// Two-character names (sharp, flat) win over the bare letter.
	function automatic root_t root_lookup(input logic [7:0] c0, input logic [7:0] c1,
			input logic has_two);
		root_t r;
		logic  sh;
		logic  fl;
		sh = has_two && (c1 == "#");
		fl = has_two && (c1 == "b");
		r = '{found: 1'b1, two: 1'b0, pc: 4'd0};
		case (c0)
			"C": begin
				if (sh) r = '{1'b1, 1'b1, 4'd1};
				else if (fl) r = '{1'b1, 1'b1, 4'd11};
				else r = '{1'b1, 1'b0, 4'd0};
			end
			"D": begin
				if (sh) r = '{1'b1, 1'b1, 4'd3};
				else if (fl) r = '{1'b1, 1'b1, 4'd1};
				else r = '{1'b1, 1'b0, 4'd2};
			end
			"E": begin
				if (fl) r = '{1'b1, 1'b1, 4'd3};
				else r = '{1'b1, 1'b0, 4'd4};
			end
			"F": begin
				if (fl) r = '{1'b1, 1'b1, 4'd4};
				else if (sh) r = '{1'b1, 1'b1, 4'd6};
				else r = '{1'b1, 1'b0, 4'd5};
			end
			"G": begin
				if (fl) r = '{1'b1, 1'b1, 4'd6};
				else if (sh) r = '{1'b1, 1'b1, 4'd8};
				else r = '{1'b1, 1'b0, 4'd7};
			end
			"A": begin
				if (fl) r = '{1'b1, 1'b1, 4'd8};
				else if (sh) r = '{1'b1, 1'b1, 4'd10};
				else r = '{1'b1, 1'b0, 4'd9};
			end
			"B": begin
				if (fl) r = '{1'b1, 1'b1, 4'd10};
				else r = '{1'b1, 1'b0, 4'd11};
			end
			default: r = '{1'b0, 1'b0, 4'd0};
		endcase
		return r;
	endfunction

	// Quality suffix must match exactly in length and text.
	function automatic qual_t qual_lookup(input logic [3:0][7:0] s, input logic [2:0] qlen);
		qual_t q;
		q = '{found: 1'b0, four: 1'b0, iv1: 4'd0, iv2: 4'd0, iv3: 4'd0};
		case (qlen)
			3'd0: q = '{1'b1, 1'b0, 4'd4, 4'd7, 4'd0};
			3'd1: begin
				if (s[0] == "7") q = '{1'b1, 1'b1, 4'd4, 4'd7, 4'd10};
				else if (s[0] == "m") q = '{1'b1, 1'b0, 4'd3, 4'd7, 4'd0};
			end
			3'd2: begin
				if (s[0] == "m" && s[1] == "7") q = '{1'b1, 1'b1, 4'd3, 4'd7, 4'd10};
				else if (s[0] == "m" && s[1] == "6") q = '{1'b1, 1'b1, 4'd3, 4'd7, 4'd9};
			end
			3'd3: begin
				if (s[0] == "s" && s[1] == "u" && s[2] == "s")
					q = '{1'b1, 1'b0, 4'd5, 4'd7, 4'd0};
				else if (s[0] == "d" && s[1] == "i" && s[2] == "m")
					q = '{1'b1, 1'b0, 4'd3, 4'd6, 4'd0};
			end
			3'd4: begin
				if (s[0] == "m" && s[1] == "7" && s[2] == "b" && s[3] == "5")
					q = '{1'b1, 1'b1, 4'd3, 4'd6, 4'd10};
				else if (s[0] == "m" && s[1] == "a" && s[2] == "j" && s[3] == "7")
					q = '{1'b1, 1'b1, 4'd4, 4'd7, 4'd11};
				else if (s[0] == "d" && s[1] == "i" && s[2] == "m" && s[3] == "7")
					q = '{1'b1, 1'b1, 4'd3, 4'd6, 4'd9};
			end
			default: q = '{1'b0, 1'b0, 4'd0, 4'd0, 4'd0};
		endcase
		return q;
	endfunction

endpackage

// ===== sv/chord_symbol_to_note_events_top.sv =====
// ----------------------------------------------------------------------------
// chord_symbol_to_note_events_top
// Splits a chord progression string, one character per word, into dash
// separated tokens and emits one note event word per tone or bad token.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// in        slave      in_valid / in_ready    character, end_of_string
// out       master     out_valid / out_ready  note, event_start, event_duration,
//                                             event_instrument, event_amplitude,
//                                             unrecognized, last_of_chord
// cfg       slave      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Flow: a character that does not finish a token is taken in S_IDLE. A word
// that finishes a non-empty token is accepted, passes the S_PARSE chord decode
// register stage, then gives one event word per cycle (one, three or four)
// while out_ready is high; the single output register set limits this.
// Reset: all control state clears at once; no clearing pass.
// Stalls: out_ready low holds the current event word; no input is taken
// until the last event of the chord has left.
// Configuration words are always taken (cfg_ready is high).
// ----------------------------------------------------------------------------
module chord_symbol_to_note_events_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// input characters
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     character,
	input  logic                           end_of_string,
	// note events
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     note,
	output logic [31:0]                    event_start,
	output logic [23:0]                    event_duration,
	output logic [11:0]                    event_instrument,
	output logic [15:0]                    event_amplitude,
	output logic                           unrecognized,
	output logic                           last_of_chord,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cse_pkg::CFG_DATA_W-1:0] cfg_data
);

	cse_pkg::cmd_t cmd;
	cse_pkg::sts_t sts;

	// registers sit in the datapath; a write is registered on the edge that takes it
	assign cfg_ready = 1'b1;

	cse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	cse_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.character        (character),
		.end_of_string    (end_of_string),
		.note             (note),
		.event_start      (event_start),
		.event_duration   (event_duration),
		.event_instrument (event_instrument),
		.event_amplitude  (event_amplitude),
		.unrecognized     (unrecognized),
		.last_of_chord    (last_of_chord)
	);

endmodule

// ===== sv/cse_ctrl.sv =====
// ----------------------------------------------------------------------------
// cse_ctrl
// Sequencer: take input words, decode a finished token, then hand out its
// note events one word at a time.
// ----------------------------------------------------------------------------
module cse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          out_ready,
	input  cse_pkg::sts_t sts,
	output logic          in_ready,
	output logic          out_valid,
	output cse_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_PARSE = 3'b010,
		S_EMIT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);

	assign cmd.take    = in_valid && in_ready;
	assign cmd.parse   = (state_q == S_PARSE);
	assign cmd.advance = out_valid && out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.take && sts.tok_done) state_d = S_PARSE;
			end
			S_PARSE: state_d = S_EMIT;
			S_EMIT: begin
				if (cmd.advance && sts.last_tone) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/cse_dp.sv =====
// ----------------------------------------------------------------------------
// cse_dp
// Datapath: configuration registers, token buffer, running time, chord
// decode and the output event registers.
// ----------------------------------------------------------------------------
module cse_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cse_pkg::cmd_t                       cmd,
	output cse_pkg::sts_t                       sts,
	input  logic                                cfg_valid,
	input  logic [cse_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cse_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [7:0]                          character,
	input  logic                                end_of_string,
	output logic [7:0]                          note,
	output logic [31:0]                         event_start,
	output logic [23:0]                         event_duration,
	output logic [11:0]                         event_instrument,
	output logic [15:0]                         event_amplitude,
	output logic                                unrecognized,
	output logic                                last_of_chord
);

	// configuration
	logic [4:0]  octave_q;
	logic [31:0] start_cfg_q;
	logic [23:0] dur_q;
	logic [11:0] instr_q;
	logic [15:0] amp_q;

	// scan state
	logic [cse_pkg::TOKEN_DEPTH-1:0][7:0] tok_q;
	logic [cse_pkg::LEN_W-1:0]            len_q;
	logic [cse_pkg::LEN_W-1:0]            len_after;
	logic [31:0]                          rt_q;
	logic [cse_pkg::CHARS_W-1:0]          seen_q;
	logic                                 sos_q;
	logic                                 in_range;
	logic                                 is_dash;
	logic                                 append;

	// event registers
	logic [3:0][7:0] notes_q;
	logic            four_q;
	logic            unrec_q;
	logic [1:0]      tone_q;
	logic [31:0]     ev_start_q;
	logic [23:0]     ev_dur_q;
	logic [11:0]     ev_instr_q;
	logic [15:0]     ev_amp_q;

	// decode
	cse_pkg::root_t  root;
	cse_pkg::qual_t  qual;
	logic [3:0][7:0] rest;
	logic [2:0]      qlen;
	logic [3:0]      oct_eff;
	logic [4:0]      oct_p1;
	logic [7:0]      base;
	logic            hit;
	logic [32:0]     rt_sum;

	assign in_range = (seen_q < cse_pkg::CHARS_W'(cse_pkg::MAX_CHARS));
	assign is_dash  = (character == cse_pkg::DASH);
	assign append   = in_range && !is_dash;

	always_comb begin
		len_after = len_q;
		if (append) begin
			if (len_q < cse_pkg::LEN_W'(cse_pkg::TOKEN_DEPTH)) len_after = len_q + 3'd1;
			else len_after = cse_pkg::TOKEN_OVERFLOW;
		end
	end

	assign sts.tok_done  = ((in_range && is_dash) || end_of_string) && (len_after != '0);
	assign sts.last_tone = unrec_q || (four_q ? (tone_q == 2'd3) : (tone_q == 2'd2));

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_q    <= 5'h1f;
			start_cfg_q <= '0;
			dur_q       <= '0;
			instr_q     <= 12'd1;
			amp_q       <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cse_pkg::REG_OCTAVE:     octave_q    <= cfg_data[4:0];
				cse_pkg::REG_START:      start_cfg_q <= cfg_data[31:0];
				cse_pkg::REG_DURATION:   dur_q       <= cfg_data[23:0];
				cse_pkg::REG_INSTRUMENT: instr_q     <= cfg_data[11:0];
				cse_pkg::REG_AMPLITUDE:  amp_q       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// chord decode of the held token
	assign root = cse_pkg::root_lookup(tok_q[0], tok_q[1], len_q >= 3'd2);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rest[i] = root.two ? tok_q[i+2] : tok_q[i+1];
		end
	end

	assign qlen    = len_q - (root.two ? 3'd2 : 3'd1);
	assign qual    = cse_pkg::qual_lookup(rest, qlen);
	assign hit     = (len_q <= 3'(cse_pkg::TOKEN_DEPTH)) && root.found && qual.found;
	assign oct_eff = octave_q[4] ? 4'd4 : octave_q[3:0];
	assign oct_p1  = {1'b0, oct_eff} + 5'd1;
	assign base    = {oct_p1, 3'b000} + {1'b0, oct_p1, 2'b00} + {4'd0, root.pc};
	assign rt_sum  = {1'b0, rt_q} + {9'd0, dur_q};

	// token buffer, running time, string position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			rt_q   <= '0;
			seen_q <= '0;
			sos_q  <= 1'b1;
		end else if (cmd.take) begin
			if (sos_q) rt_q <= start_cfg_q;
			sos_q  <= end_of_string;
			len_q  <= len_after;
			if (end_of_string) seen_q <= '0;
			else if (in_range) seen_q <= seen_q + 1'b1;
		end else if (cmd.parse) begin
			len_q <= '0;
			rt_q  <= rt_sum[32] ? '1 : rt_sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && append && (len_q < cse_pkg::LEN_W'(cse_pkg::TOKEN_DEPTH))) begin
			tok_q[len_q] <= character;
		end
	end

	// event registers
	always_ff @(posedge clk) begin
		if (cmd.parse) begin
			notes_q[0] <= base;
			notes_q[1] <= base + {4'd0, qual.iv1};
			notes_q[2] <= base + {4'd0, qual.iv2};
			notes_q[3] <= base + {4'd0, qual.iv3};
			four_q     <= qual.four;
			unrec_q    <= !hit;
			ev_start_q <= rt_q;
			ev_dur_q   <= dur_q;
			ev_instr_q <= instr_q;
			ev_amp_q   <= amp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q <= '0;
		end else if (cmd.parse) begin
			tone_q <= '0;
		end else if (cmd.advance) begin
			tone_q <= tone_q + 2'd1;
		end
	end

	assign note             = unrec_q ? 8'd0 : notes_q[tone_q];
	assign event_start      = ev_start_q;
	assign event_duration   = ev_dur_q;
	assign event_instrument = ev_instr_q;
	assign event_amplitude  = ev_amp_q;
	assign unrecognized     = unrec_q;
	assign last_of_chord    = sts.last_tone;

endmodule

// ===== sv/cse_checker.sv =====
// ----------------------------------------------------------------------------
// cse_checker
// Port level checks for the chord symbol to note event block.
// ----------------------------------------------------------------------------
module cse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  note,
	input logic [31:0] event_start,
	input logic        unrecognized,
	input logic        last_of_chord
);

	// never take a character while an event word is on show
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while event pending");

	// a stalled event word holds its start time
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_start))
		else $error("stalled event word changed");

	// flagged token gives one word with note zero
	a_unrec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unrecognized |-> last_of_chord && (note == 8'd0))
		else $error("bad unrecognized word");

	// tones of a chord follow back to back and share a start time
	a_chord: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_chord |=>
			out_valid && $stable(event_start) && !in_ready)
		else $error("chord broken up");

endmodule

bind chord_symbol_to_note_events_top cse_checker u_cse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.note          (note),
	.event_start   (event_start),
	.unrecognized  (unrecognized),
	.last_of_chord (last_of_chord)
);
